[design/u8wd_pkg.sv]
package u8wd_pkg;

  // Lead byte bounds
  localparam logic [7:0] LeadAsciiEnd  = 8'h80;
  localparam logic [7:0] Lead2Min      = 8'hC2;
  localparam logic [7:0] Lead2Max      = 8'hDF;
  localparam logic [7:0] Lead3Min      = 8'hE0;
  localparam logic [7:0] Lead3Max      = 8'hEF;
  localparam logic [7:0] Lead4Min      = 8'hF0;
  localparam logic [7:0] Lead4Max      = 8'hF4;

  // Lead bytes with a narrowed second-byte range
  localparam logic [7:0] LeadE0        = 8'hE0;
  localparam logic [7:0] LeadEd        = 8'hED;
  localparam logic [7:0] LeadF0        = 8'hF0;
  localparam logic [7:0] LeadF4        = 8'hF4;

  // Continuation byte bounds
  localparam logic [7:0] ContMin       = 8'h80;
  localparam logic [7:0] ContMax       = 8'hBF;
  localparam logic [7:0] E0SecondMin   = 8'hA0;
  localparam logic [7:0] EdSecondMax   = 8'h9F;
  localparam logic [7:0] F0SecondMin   = 8'h90;
  localparam logic [7:0] F4SecondMax   = 8'h8F;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;

  localparam logic [LenWidth-1:0] LenOne   = 3'd1;
  localparam logic [LenWidth-1:0] LenTwo   = 3'd2;
  localparam logic [LenWidth-1:0] LenThree = 3'd3;
  localparam logic [LenWidth-1:0] LenFour  = 3'd4;

  typedef struct packed {
    logic [7:0]          byte_first;
    logic [7:0]          byte_second;
    logic [7:0]          byte_third;
    logic [7:0]          byte_fourth;
    logic [LenWidth-1:0] bytes_available;
  } win_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] length_used;
    logic                invalid;
  } res_t;

endpackage

[design/u8wd_decode.sv]
module u8wd_decode (
  input  u8wd_pkg::win_t win_i,
  output u8wd_pkg::res_t res_o
);

  logic [7:0]                    b0, b1, b2, b3;
  logic [u8wd_pkg::LenWidth-1:0] need;
  logic                          lead_ok;
  logic [7:0]                    lo2, hi2;
  logic                          second_ok, third_ok, fourth_ok;
  logic                          seq_ok;
  logic [u8wd_pkg::CpWidth-1:0]  cp;

  assign b0 = win_i.byte_first;
  assign b1 = win_i.byte_second;
  assign b2 = win_i.byte_third;
  assign b3 = win_i.byte_fourth;

  always_comb begin
    lead_ok = 1'b1;
    need    = u8wd_pkg::LenOne;
    lo2     = u8wd_pkg::ContMin;
    hi2     = u8wd_pkg::ContMax;
    if (b0 < u8wd_pkg::LeadAsciiEnd) begin
      need = u8wd_pkg::LenOne;
    end else if (b0 >= u8wd_pkg::Lead2Min && b0 <= u8wd_pkg::Lead2Max) begin
      need = u8wd_pkg::LenTwo;
    end else if (b0 >= u8wd_pkg::Lead3Min && b0 <= u8wd_pkg::Lead3Max) begin
      need = u8wd_pkg::LenThree;
      // reject overlong forms and surrogates
      if (b0 == u8wd_pkg::LeadE0) lo2 = u8wd_pkg::E0SecondMin;
      if (b0 == u8wd_pkg::LeadEd) hi2 = u8wd_pkg::EdSecondMax;
    end else if (b0 >= u8wd_pkg::Lead4Min && b0 <= u8wd_pkg::Lead4Max) begin
      need = u8wd_pkg::LenFour;
      // reject overlong forms and values above 10FFFF
      if (b0 == u8wd_pkg::LeadF0) lo2 = u8wd_pkg::F0SecondMin;
      if (b0 == u8wd_pkg::LeadF4) hi2 = u8wd_pkg::F4SecondMax;
    end else begin
      lead_ok = 1'b0;
    end
  end

  assign second_ok = (b1 >= lo2) && (b1 <= hi2);
  assign third_ok  = (b2 >= u8wd_pkg::ContMin) && (b2 <= u8wd_pkg::ContMax);
  assign fourth_ok = (b3 >= u8wd_pkg::ContMin) && (b3 <= u8wd_pkg::ContMax);

  // a count above four never limits a four-byte sequence, so no clamp is needed
  always_comb begin
    seq_ok = lead_ok && (need <= win_i.bytes_available);
    cp     = '0;
    unique case (need)
      u8wd_pkg::LenOne: begin
        cp = {14'd0, b0[6:0]};
      end
      u8wd_pkg::LenTwo: begin
        seq_ok = seq_ok && second_ok;
        cp     = {10'd0, b0[4:0], b1[5:0]};
      end
      u8wd_pkg::LenThree: begin
        seq_ok = seq_ok && second_ok && third_ok;
        cp     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end
      u8wd_pkg::LenFour: begin
        seq_ok = seq_ok && second_ok && third_ok && fourth_ok;
        cp     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end
      default: begin
        seq_ok = 1'b0;
      end
    endcase
  end

  assign res_o.code_point  = seq_ok ? cp : '0;
  assign res_o.length_used = seq_ok ? need : u8wd_pkg::LenOne;
  assign res_o.invalid     = ~seq_ok;

endmodule

[design/utf8_window_decoder_core.sv]
// Channel   Handshake             Payload
// command   start_i / busy_o      byte_first_i..byte_fourth_i, bytes_available_i
// result    result_valid_o        code_point_o, length_used_o, invalid_o
//
// One window is taken every cycle; busy_o never rises.
// Each result passes first through the window register, then through the decode
// logic into the result register.
// Reset clears the valid flags of both stages; payload registers are not reset.
// The receiver cannot stall, so nothing is held back.
module utf8_window_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  byte_first_i,
  input  logic [7:0]  byte_second_i,
  input  logic [7:0]  byte_third_i,
  input  logic [7:0]  byte_fourth_i,
  input  logic [2:0]  bytes_available_i,
  output logic        result_valid_o,
  output logic [20:0] code_point_o,
  output logic [2:0]  length_used_o,
  output logic        invalid_o
);

  u8wd_pkg::win_t win_d, win_q;
  u8wd_pkg::res_t res_d, res_q;
  logic           win_valid_q;
  logic           res_valid_q;
  logic           accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign win_d.byte_first      = byte_first_i;
  assign win_d.byte_second     = byte_second_i;
  assign win_d.byte_third      = byte_third_i;
  assign win_d.byte_fourth     = byte_fourth_i;
  assign win_d.bytes_available = bytes_available_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      win_valid_q <= accept;
      res_valid_q <= win_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
    if (win_valid_q) begin
      res_q <= res_d;
    end
  end

  u8wd_decode u_decode (
    .win_i (win_q),
    .res_o (res_d)
  );

  assign result_valid_o = res_valid_q;
  assign code_point_o   = res_q.code_point;
  assign length_used_o  = res_q.length_used;
  assign invalid_o      = res_q.invalid;

endmodule
